// ===== hdl/fba_pkg.sv =====
// Shared types and constants for the file block allocator.
// Used by every module of the block but fba_ram; depends on nothing.
package fba_pkg;

    localparam int INODES     = 16;
    localparam int BLOCKS     = 64;
    localparam int BLK_BYTES  = 4096;

    localparam int INO_W      = $clog2(INODES);
    localparam int BLK_W      = $clog2(BLOCKS);
    localparam int CNT_W      = BLK_W + 1;
    localparam int NI_W       = INO_W + 1;
    localparam int BS_W       = 13;
    localparam int OFF_W      = 12;
    localparam int LEN_W      = 18;
    localparam int SIZE_W     = 19;
    localparam int DIV_W      = 19;
    localparam int LIST_DEPTH = INODES * BLOCKS;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SIZE_W-1:0] SIZE_CAP = '1;
    localparam logic [BS_W-1:0]   BS_RESET = BS_W'(512);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INODES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS     = 2'd2;

    typedef enum logic [1:0] {
        OP_CREATE, OP_APPEND, OP_DELETE, OP_MAP
    } t_op;

    typedef enum logic [2:0] {
        ST_OK, ST_NO_FREE, ST_NO_SPACE, ST_BAD_INODE, ST_PAST_END
    } t_status;

    // one micro-operation per cycle, issued by the controller
    typedef enum logic [4:0] {
        CMD_NONE, CMD_HOLD, CMD_LOAD, CMD_BAD, CMD_ISCAN, CMD_PCNT, CMD_FCNT,
        CMD_CREATE, CMD_DIV_SZ, CMD_SPACE, CMD_DIV_NEED, CMD_NEED, CMD_REFUSE,
        CMD_ALLOC, CMD_APPEND, CMD_DEL_RD, CMD_DELETE, CMD_DIV_OFF, CMD_MAP_RD,
        CMD_MAP, CMD_OUT
    } t_cmd;

    // datapath status seen by the controller
    typedef struct packed {
        t_op  op;
        logic ino_ok;
        logic scan_end;
        logic div_busy;
        logic len_gt_space;
        logic need_gt_free;
    } t_sts;

endpackage

// ===== hdl/fba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fba_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on fba_pkg for operand widths.
module fba_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [fba_pkg::DIV_W-1:0] i_num,
    input  logic [fba_pkg::BS_W-1:0]  i_den,
    output logic                      o_busy,
    output logic [fba_pkg::DIV_W-1:0] o_quo,
    output logic [fba_pkg::BS_W-1:0]  o_rem
);
    import fba_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic            r_busy;
    logic [CW-1:0]   r_cnt;
    logic [DIV_W-1:0] r_num;
    logic [BS_W-1:0] r_rem;
    logic [BS_W:0]   trial;
    logic [BS_W:0]   diff;
    logic            ge;

    // trial subtract of the shifted partial remainder
    always_comb begin
        trial = {r_rem, r_num[DIV_W-1]};
        ge    = trial >= {1'b0, i_den};
        diff  = trial - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], ge};
            r_rem <= ge ? diff[BS_W-1:0] : trial[BS_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/fba_dp.sv =====
// Datapath: config registers, bitmaps, per-file counts and sizes, block list
// RAM, divider and scan counter. Depends on fba_pkg, fba_ram, fba_div.
module fba_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fba_pkg::t_cmd                 i_cmd,
    output fba_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_valid,
    input  logic [fba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fba_pkg::BS_W-1:0]      i_cfg_data,
    input  logic [1:0]                    i_op,
    input  logic [fba_pkg::INO_W-1:0]     i_inode,
    input  logic [fba_pkg::LEN_W-1:0]     i_length,
    input  logic [fba_pkg::LEN_W-1:0]     i_byte_offset,
    output logic [2:0]                    o_status,
    output logic [fba_pkg::INO_W-1:0]     o_inode_out,
    output logic [fba_pkg::BLK_W-1:0]     o_block_out,
    output logic [fba_pkg::CNT_W-1:0]     o_new_blocks,
    output logic [fba_pkg::OFF_W-1:0]     o_offset_in_block,
    output logic [fba_pkg::BS_W-1:0]      o_bytes_valid,
    output logic [fba_pkg::CNT_W-1:0]     o_free_block_count,
    output logic [fba_pkg::SIZE_W-1:0]    o_file_size
);
    import fba_pkg::*;

    localparam int LIST_AW = $clog2(LIST_DEPTH);

    // configuration
    logic [BS_W-1:0]   r_bs;
    logic [NI_W-1:0]   r_ni;
    logic [CNT_W-1:0]  r_nb;
    logic [BS_W-1:0]   eff_bs;
    logic [NI_W-1:0]   eff_ni;
    logic [CNT_W-1:0]  eff_nb;

    // current item
    t_op               r_op;
    logic [INO_W-1:0]  r_ino;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_off;

    // allocator state
    logic [INODES-1:0] r_inode_used;
    logic [BLOCKS-1:0] r_block_used;
    logic [CNT_W-1:0]  r_bcnt  [INODES];
    logic [SIZE_W-1:0] r_lsize [INODES];

    // scan accumulators
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_fcnt;
    logic [BLK_W-1:0]  r_fb;
    logic              r_fb_ok;
    logic [INO_W-1:0]  r_fi;
    logic              r_fi_ok;
    logic [CNT_W-1:0]  r_taken;
    logic [BLK_W-1:0]  r_first;
    logic              r_first_ok;
    logic              r_del_pend;

    // append / map intermediates
    logic [BS_W-1:0]   r_space;
    logic              r_len_gt;
    logic [DIV_W-1:0]  r_need;
    logic              r_map_ok;

    // result
    t_status           r_status;
    logic [INO_W-1:0]  r_ino_out;
    logic [BLK_W-1:0]  r_blk;
    logic [CNT_W-1:0]  r_newb;
    logic [OFF_W-1:0]  r_inb;
    logic [BS_W-1:0]   r_bv;

    // combinational
    logic [CNT_W-1:0]  cur_bcnt;
    logic [SIZE_W-1:0] cur_size;
    logic [CNT_W-1:0]  scan_lim;
    logic              step;
    logic              scan_cmd;
    logic [BLK_W-1:0]  idx_blk;
    logic              blk_free;
    logic              take;
    logic              create_ok;
    logic [BS_W-1:0]   space_c;
    logic              len_gt_c;
    logic [DIV_W-1:0]  need_num;
    logic [SIZE_W:0]   ssum;
    logic [SIZE_W-1:0] new_size;
    logic [DIV_W-1:0]  msum;
    logic [DIV_W-1:0]  mend;
    logic [DIV_W-1:0]  mv;
    logic [BS_W-1:0]   room;
    logic [BS_W-1:0]   bv_c;
    logic              map_ok_c;

    logic              div_start;
    logic [DIV_W-1:0]  div_num;
    logic              div_busy;
    logic [DIV_W-1:0]  div_quo;
    logic [BS_W-1:0]   div_rem;

    logic              ram_we;
    logic [LIST_AW-1:0] ram_waddr;
    logic [BLK_W-1:0]  ram_wdata;
    logic [LIST_AW-1:0] ram_raddr;
    logic [BLK_W-1:0]  ram_rdata;

    // effective register values
    always_comb begin
        if (r_bs == '0) begin
            eff_bs = BS_W'(1);
        end else if (r_bs > BS_W'(BLK_BYTES)) begin
            eff_bs = BS_W'(BLK_BYTES);
        end else begin
            eff_bs = r_bs;
        end
        eff_ni = (r_ni > NI_W'(INODES)) ? NI_W'(INODES) : r_ni;
        eff_nb = (r_nb > CNT_W'(BLOCKS)) ? CNT_W'(BLOCKS) : r_nb;
    end

    // scan control
    always_comb begin
        cur_bcnt = r_bcnt[r_ino];
        cur_size = r_lsize[r_ino];
        case (i_cmd)
            CMD_ISCAN:  scan_lim = CNT_W'(eff_ni);
            CMD_DEL_RD: scan_lim = cur_bcnt;
            default:    scan_lim = eff_nb;
        endcase
        step      = r_idx < scan_lim;
        scan_cmd  = i_cmd inside {CMD_ISCAN, CMD_PCNT, CMD_FCNT, CMD_ALLOC, CMD_DEL_RD};
        idx_blk   = r_idx[BLK_W-1:0];
        blk_free  = !r_block_used[idx_blk];
        take      = (i_cmd == CMD_ALLOC) && step && blk_free
                    && (DIV_W'(r_taken) < r_need) && (cur_bcnt < CNT_W'(BLOCKS));
        create_ok = r_fi_ok && r_fb_ok;
    end

    // append arithmetic: room left in the last block, blocks needed and new size
    always_comb begin
        if (cur_bcnt == '0) begin
            space_c = '0;
        end else if (cur_size == '0) begin
            space_c = eff_bs;
        end else if (div_rem != '0) begin
            space_c = eff_bs - div_rem;
        end else begin
            space_c = '0;
        end
        len_gt_c = r_len > LEN_W'(space_c);
        need_num = DIV_W'(r_len) - DIV_W'(r_space) + DIV_W'(eff_bs) - DIV_W'(1);
        ssum     = (SIZE_W+1)'(cur_size) + (SIZE_W+1)'(r_len);
        new_size = ssum[SIZE_W] ? SIZE_CAP : ssum[SIZE_W-1:0];
    end

    // map arithmetic
    always_comb begin
        msum     = DIV_W'(r_off) + DIV_W'(r_len);
        mend     = (msum > cur_size) ? cur_size : msum;
        mv       = mend - DIV_W'(r_off);
        room     = eff_bs - div_rem;
        bv_c     = (mv > DIV_W'(room)) ? room : mv[BS_W-1:0];
        map_ok_c = (DIV_W'(r_off) < cur_size) && (div_quo < DIV_W'(cur_bcnt))
                   && (div_quo < DIV_W'(BLOCKS));
    end

    // divider operand select
    always_comb begin
        div_start = i_cmd inside {CMD_DIV_SZ, CMD_DIV_NEED, CMD_DIV_OFF};
        case (i_cmd)
            CMD_DIV_SZ:   div_num = cur_size;
            CMD_DIV_NEED: div_num = need_num;
            default:      div_num = DIV_W'(r_off);
        endcase
    end

    // block list RAM ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {r_ino, idx_blk};
        ram_wdata = idx_blk;
        if (i_cmd == CMD_CREATE) begin
            ram_we    = create_ok;
            ram_waddr = {r_fi, {BLK_W{1'b0}}};
            ram_wdata = r_fb;
        end else if (take) begin
            ram_we    = 1'b1;
            ram_waddr = {r_ino, cur_bcnt[BLK_W-1:0]};
        end
        ram_raddr = (i_cmd == CMD_MAP_RD) ? {r_ino, div_quo[BLK_W-1:0]} : {r_ino, idx_blk};
    end

    fba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (eff_bs),
        .o_busy  (div_busy),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    fba_ram #(.WIDTH(BLK_W), .DEPTH(LIST_DEPTH)) u_list (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // config, bitmaps, counts, sizes and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs         <= BS_RESET;
            r_ni         <= NI_W'(INODES);
            r_nb         <= CNT_W'(BLOCKS);
            r_inode_used <= '0;
            r_block_used <= '0;
            for (int i = 0; i < INODES; i++) begin
                r_bcnt[i]  <= '0;
                r_lsize[i] <= '0;
            end
            r_idx      <= '0;
            r_fcnt     <= '0;
            r_fb_ok    <= 1'b0;
            r_fi_ok    <= 1'b0;
            r_taken    <= '0;
            r_first_ok <= 1'b0;
            r_del_pend <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BLOCK_SIZE: r_bs <= i_cfg_data;
                    CFG_INODES:     r_ni <= i_cfg_data[NI_W-1:0];
                    CFG_BLOCKS:     r_nb <= i_cfg_data[CNT_W-1:0];
                    default:        ;
                endcase
            end

            // free the block read by the previous delete step
            r_del_pend <= (i_cmd == CMD_DEL_RD) && step;
            if (r_del_pend) begin
                r_block_used[ram_rdata] <= 1'b0;
            end

            // scans restart after any other command but hold and output
            if (!scan_cmd && i_cmd != CMD_HOLD && i_cmd != CMD_OUT) begin
                r_idx      <= '0;
                r_fcnt     <= '0;
                r_fb_ok    <= 1'b0;
                r_taken    <= '0;
                r_first_ok <= 1'b0;
            end

            case (i_cmd)
                CMD_LOAD: begin
                    r_fi_ok <= 1'b0;
                end
                CMD_ISCAN: begin
                    if (step) begin
                        if (!r_fi_ok && !r_inode_used[r_idx[INO_W-1:0]]) begin
                            r_fi_ok <= 1'b1;
                            r_fi    <= r_idx[INO_W-1:0];
                        end
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                CMD_PCNT, CMD_FCNT: begin
                    if (step) begin
                        if (blk_free) begin
                            r_fcnt <= r_fcnt + CNT_W'(1);
                            if (!r_fb_ok) begin
                                r_fb_ok <= 1'b1;
                                r_fb    <= idx_blk;
                            end
                        end
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                CMD_ALLOC: begin
                    if (step) begin
                        if (take) begin
                            r_block_used[idx_blk] <= 1'b1;
                            r_bcnt[r_ino]         <= cur_bcnt + CNT_W'(1);
                            r_taken               <= r_taken + CNT_W'(1);
                            if (!r_first_ok) begin
                                r_first_ok <= 1'b1;
                                r_first    <= idx_blk;
                            end
                        end
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                CMD_DEL_RD: begin
                    if (step) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                CMD_CREATE: begin
                    if (create_ok) begin
                        r_inode_used[r_fi] <= 1'b1;
                        r_block_used[r_fb] <= 1'b1;
                        r_lsize[r_fi]      <= '0;
                        r_bcnt[r_fi]       <= CNT_W'(1);
                    end
                end
                CMD_APPEND: begin
                    r_lsize[r_ino] <= new_size;
                end
                CMD_DELETE: begin
                    r_inode_used[r_ino] <= 1'b0;
                    r_bcnt[r_ino]       <= '0;
                    r_lsize[r_ino]      <= '0;
                end
                default: ;
            endcase
        end
    end

    // item, intermediate and result registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_op      <= t_op'(i_op);
                r_ino     <= i_inode;
                r_len     <= i_length;
                r_off     <= i_byte_offset;
                r_status  <= ST_OK;
                r_ino_out <= (t_op'(i_op) == OP_CREATE) ? '0 : i_inode;
                r_blk     <= '0;
                r_newb    <= '0;
                r_inb     <= '0;
                r_bv      <= '0;
            end
            CMD_BAD: r_status <= ST_BAD_INODE;
            CMD_CREATE: begin
                if (create_ok) begin
                    r_ino_out <= r_fi;
                    r_blk     <= r_fb;
                    r_newb    <= CNT_W'(1);
                end else begin
                    r_status <= ST_NO_FREE;
                end
            end
            CMD_SPACE: begin
                r_space  <= space_c;
                r_len_gt <= len_gt_c;
            end
            CMD_NEED: r_need <= r_len_gt ? div_quo : '0;
            CMD_REFUSE: r_status <= ST_NO_SPACE;
            CMD_APPEND: begin
                r_blk  <= r_first_ok ? r_first : '0;
                r_newb <= r_need[CNT_W-1:0];
            end
            CMD_MAP_RD: begin
                r_map_ok <= map_ok_c;
                if (map_ok_c) begin
                    r_inb <= div_rem[OFF_W-1:0];
                    r_bv  <= bv_c;
                end
            end
            CMD_MAP: begin
                if (r_map_ok) begin
                    r_blk <= ram_rdata;
                end else begin
                    r_status <= ST_PAST_END;
                end
            end
            CMD_OUT: begin
                o_status           <= r_status;
                o_inode_out        <= r_ino_out;
                o_block_out        <= r_blk;
                o_new_blocks       <= r_newb;
                o_offset_in_block  <= r_inb;
                o_bytes_valid      <= r_bv;
                o_free_block_count <= r_fcnt;
                o_file_size        <= (r_op == OP_CREATE) ? '0 : cur_size;
            end
            default: ;
        endcase
    end

    // status to the controller
    always_comb begin
        o_sts.op           = r_op;
        o_sts.ino_ok       = r_inode_used[r_ino];
        o_sts.scan_end     = !step;
        o_sts.div_busy     = div_busy;
        o_sts.len_gt_space = len_gt_c;
        o_sts.need_gt_free = r_need > DIV_W'(r_fcnt);
    end

endmodule

// ===== hdl/fba_ctrl.sv =====
// Controller: sequences each item through the datapath and owns the item and result handshakes.
// Depends on fba_pkg.
module fba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  fba_pkg::t_sts i_sts,
    output fba_pkg::t_cmd o_cmd
);
    import fba_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_ISCAN, S_CGAP, S_PCNTC, S_CREATE, S_BAD,
        S_DSZ, S_DSZW, S_SPACE, S_DNEED, S_DNEEDW, S_NEED, S_PCNTA, S_DECIDE,
        S_REFUSE, S_ALLOC, S_APPEND, S_DEL, S_DELC, S_DOFF, S_DOFFW, S_MAPRD,
        S_MAP, S_FCNT, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid;
    t_cmd   cmd;

    // next state and command
    always_comb begin
        n_state = r_state;
        cmd     = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd     = CMD_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.op == OP_CREATE) begin
                    n_state = S_ISCAN;
                end else if (!i_sts.ino_ok) begin
                    n_state = S_BAD;
                end else begin
                    case (i_sts.op)
                        OP_APPEND: n_state = S_DSZ;
                        OP_DELETE: n_state = S_DEL;
                        default:   n_state = S_DOFF;
                    endcase
                end
            end
            S_ISCAN: begin
                cmd = CMD_ISCAN;
                if (i_sts.scan_end) n_state = S_CGAP;
            end
            S_CGAP:   n_state = S_PCNTC;
            S_PCNTC: begin
                cmd = CMD_PCNT;
                if (i_sts.scan_end) n_state = S_CREATE;
            end
            S_CREATE: begin
                cmd     = CMD_CREATE;
                n_state = S_FCNT;
            end
            S_BAD: begin
                cmd     = CMD_BAD;
                n_state = S_FCNT;
            end
            S_DSZ: begin
                cmd     = CMD_DIV_SZ;
                n_state = S_DSZW;
            end
            S_DSZW: begin
                if (!i_sts.div_busy) n_state = S_SPACE;
            end
            S_SPACE: begin
                cmd     = CMD_SPACE;
                n_state = i_sts.len_gt_space ? S_DNEED : S_NEED;
            end
            S_DNEED: begin
                cmd     = CMD_DIV_NEED;
                n_state = S_DNEEDW;
            end
            S_DNEEDW: begin
                if (!i_sts.div_busy) n_state = S_NEED;
            end
            S_NEED: begin
                cmd     = CMD_NEED;
                n_state = S_PCNTA;
            end
            S_PCNTA: begin
                cmd = CMD_PCNT;
                if (i_sts.scan_end) n_state = S_DECIDE;
            end
            S_DECIDE: n_state = i_sts.need_gt_free ? S_REFUSE : S_ALLOC;
            S_REFUSE: begin
                cmd     = CMD_REFUSE;
                n_state = S_FCNT;
            end
            S_ALLOC: begin
                cmd = CMD_ALLOC;
                if (i_sts.scan_end) n_state = S_APPEND;
            end
            S_APPEND: begin
                cmd     = CMD_APPEND;
                n_state = S_FCNT;
            end
            S_DEL: begin
                cmd = CMD_DEL_RD;
                if (i_sts.scan_end) n_state = S_DELC;
            end
            S_DELC: begin
                cmd     = CMD_DELETE;
                n_state = S_FCNT;
            end
            S_DOFF: begin
                cmd     = CMD_DIV_OFF;
                n_state = S_DOFFW;
            end
            S_DOFFW: begin
                if (!i_sts.div_busy) n_state = S_MAPRD;
            end
            S_MAPRD: begin
                cmd     = CMD_MAP_RD;
                n_state = S_MAP;
            end
            S_MAP: begin
                cmd     = CMD_MAP;
                n_state = S_FCNT;
            end
            S_FCNT: begin
                cmd = CMD_FCNT;
                if (i_sts.scan_end) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_valid || i_ready) begin
                    cmd     = CMD_OUT;
                    n_state = S_IDLE;
                end else begin
                    cmd = CMD_HOLD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd == CMD_OUT) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_cmd   = cmd;

endmodule

// ===== hdl/file_block_allocator_top.sv =====
// File block allocator, top level. Create sweeps up to 16 inodes and then runs
// two bitmap sweeps; append runs up to two divides and three bitmap sweeps; delete
// reads the block list RAM once per block of the file and then sweeps the bitmap;
// map runs one divide and one bitmap sweep; a bad inode runs one bitmap sweep.
// One item at a time; each bitmap sweep covers up to 64 blocks.
// Synchronous active-low reset clears all bitmaps, counts and sizes at once.
// Depends on fba_pkg, fba_ctrl, fba_dp.
module file_block_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_op,
    input  logic [fba_pkg::INO_W-1:0]     i_inode,
    input  logic [fba_pkg::LEN_W-1:0]     i_length,
    input  logic [fba_pkg::LEN_W-1:0]     i_byte_offset,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_status,
    output logic [fba_pkg::INO_W-1:0]     o_inode_out,
    output logic [fba_pkg::BLK_W-1:0]     o_block_out,
    output logic [fba_pkg::CNT_W-1:0]     o_new_blocks,
    output logic [fba_pkg::OFF_W-1:0]     o_offset_in_block,
    output logic [fba_pkg::BS_W-1:0]      o_bytes_valid,
    output logic [fba_pkg::CNT_W-1:0]     o_free_block_count,
    output logic [fba_pkg::SIZE_W-1:0]    o_file_size,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fba_pkg::BS_W-1:0]      i_cfg_data
);
    import fba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // config writes are taken only while idle with no result waiting
    assign o_cfg_ready = o_ready && !o_valid;

    fba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fba_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_valid        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_op               (i_op),
        .i_inode            (i_inode),
        .i_length           (i_length),
        .i_byte_offset      (i_byte_offset),
        .o_status           (o_status),
        .o_inode_out        (o_inode_out),
        .o_block_out        (o_block_out),
        .o_new_blocks       (o_new_blocks),
        .o_offset_in_block  (o_offset_in_block),
        .o_bytes_valid      (o_bytes_valid),
        .o_free_block_count (o_free_block_count),
        .o_file_size        (o_file_size)
    );

endmodule

// ===== hdl/fba_chk.sv =====
// Port-level checks for the file block allocator, bound to the top level.
// Depends on fba_pkg.
module fba_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [2:0]                    o_status,
    input logic [fba_pkg::BLK_W-1:0]     o_block_out,
    input logic [fba_pkg::CNT_W-1:0]     o_new_blocks,
    input logic [fba_pkg::OFF_W-1:0]     o_offset_in_block,
    input logic [fba_pkg::BS_W-1:0]      o_bytes_valid,
    input logic [fba_pkg::CNT_W-1:0]     o_free_block_count,
    input logic [fba_pkg::SIZE_W-1:0]    o_file_size
);
    import fba_pkg::*;

    // a failed item allocates nothing and names no block
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_new_blocks == '0 && o_block_out == '0)
        else $error("failed item reports allocation");

    // free count never exceeds the block pool
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_free_block_count <= CNT_W'(BLOCKS))
        else $error("free block count out of range");

    // mapped bytes stay inside a block of the largest block size
    a_map_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (14'(o_offset_in_block) + 14'(o_bytes_valid)) <= 14'(BLK_BYTES))
        else $error("mapped range crosses block end");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_file_size))
        else $error("result changed while stalled");

endmodule

bind file_block_allocator_top fba_chk u_chk (.*);

// ===== sim/tb_file_block_allocator_top.sv =====
// Self-checking testbench for file_block_allocator_top: a directed table, then
// random create/append/delete/map traffic, checked against an in-bench allocator model.
// Depends on fba_pkg and file_block_allocator_top.
module tb_file_block_allocator_top;
    import fba_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RUN_LIMIT   = 1500000;
    localparam int DRAIN_WAIT  = 300;
    localparam int LONG_HOLD   = 3000;
    localparam int SIZE_MAX    = 524287;

    typedef struct {
        t_status             status;
        logic [INO_W-1:0]    ino;
        logic [BLK_W-1:0]    blk;
        logic [CNT_W-1:0]    new_blks;
        logic [OFF_W-1:0]    in_blk;
        logic [BS_W-1:0]     valid_bytes;
        logic [CNT_W-1:0]    free_blks;
        logic [SIZE_W-1:0]   size;
    } alloc_res_t;

    typedef struct {
        t_op                 op;
        logic [INO_W-1:0]    ino;
        logic [LEN_W-1:0]    len;
        logic [LEN_W-1:0]    offs;
        int                  reps;
        bit                  typed;
        alloc_res_t          res;
    } dir_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [1:0]             i_op = '0;
    logic [INO_W-1:0]       i_inode = '0;
    logic [LEN_W-1:0]       i_length = '0;
    logic [LEN_W-1:0]       i_byte_offset = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [2:0]             o_status;
    logic [INO_W-1:0]       o_inode_out;
    logic [BLK_W-1:0]       o_block_out;
    logic [CNT_W-1:0]       o_new_blocks;
    logic [OFF_W-1:0]       o_offset_in_block;
    logic [BS_W-1:0]        o_bytes_valid;
    logic [CNT_W-1:0]       o_free_block_count;
    logic [SIZE_W-1:0]      o_file_size;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [BS_W-1:0]        i_cfg_data = '0;

    // allocator state mirrored by the bench
    int         cfg_bs, cfg_inodes, cfg_blocks;
    bit         ino_busy [INODES];
    bit         blk_busy [BLOCKS];
    int         ino_nblk [INODES];
    int         ino_list [INODES][BLOCKS];
    int         ino_size [INODES];

    alloc_res_t pending_res[$];
    dir_row_t   dir_tab[$];
    int         cycles, mismatches, n_items, n_results;
    int         status_seen [5];
    bit         no_idle, hold_req;

    file_block_allocator_top DUT (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_res.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int eff_bs();
        if (cfg_bs == 0) return 1;
        return (cfg_bs > BLK_BYTES) ? BLK_BYTES : cfg_bs;
    endfunction

    function automatic int count_idle_blocks();
        int n, c;
        n = (cfg_blocks > BLOCKS) ? BLOCKS : cfg_blocks;
        c = 0;
        for (int i = 0; i < n; i++) if (!blk_busy[i]) c++;
        return c;
    endfunction

    function automatic int lowest_free();
        int n;
        n = (cfg_blocks > BLOCKS) ? BLOCKS : cfg_blocks;
        for (int i = 0; i < n; i++) if (!blk_busy[i]) return i;
        return -1;
    endfunction

    // allocator behavior for one item; updates the mirrored state
    function automatic alloc_res_t run_alloc(t_op op, int ino, int len, int offs);
        alloc_res_t r;
        int bs, ni, fi, fb, sz, space, need, k, inb, stop, v;
        r = '{ST_OK, '0, '0, '0, '0, '0, '0, '0};
        bs = eff_bs();
        if (op == OP_CREATE) begin
            ni = (cfg_inodes > INODES) ? INODES : cfg_inodes;
            fi = -1;
            for (int i = 0; i < ni; i++)
                if (!ino_busy[i] && fi < 0) fi = i;
            fb = lowest_free();
            if (fi < 0 || fb < 0) begin
                r.status = ST_NO_FREE;
            end else begin
                ino_busy[fi] = 1; blk_busy[fb] = 1;
                ino_size[fi] = 0; ino_nblk[fi] = 1; ino_list[fi][0] = fb;
                r.ino = INO_W'(fi); r.blk = BLK_W'(fb); r.new_blks = CNT_W'(1);
            end
        end else if (!ino_busy[ino]) begin
            r.status = ST_BAD_INODE; r.ino = INO_W'(ino);
        end else if (op == OP_APPEND) begin
            sz = ino_size[ino];
            space = 0; need = 0;
            r.ino = INO_W'(ino);
            if (ino_nblk[ino] > 0) begin
                if (sz == 0) space = bs;
                else if (sz % bs != 0) space = bs - sz % bs;
            end
            if (len > space) need = (len - space + bs - 1) / bs;
            if (need > count_idle_blocks()) begin
                r.status = ST_NO_SPACE;
            end else begin
                for (k = 0; k < need; k++) begin
                    fb = lowest_free();
                    if (fb < 0 || ino_nblk[ino] >= BLOCKS) break;
                    blk_busy[fb] = 1;
                    ino_list[ino][ino_nblk[ino]] = fb;
                    ino_nblk[ino]++;
                    if (k == 0) r.blk = BLK_W'(fb);
                end
                r.new_blks = CNT_W'(need);
                sz += len;
                ino_size[ino] = (sz > SIZE_MAX) ? SIZE_MAX : sz;
            end
        end else if (op == OP_DELETE) begin
            for (int i = 0; i < ino_nblk[ino]; i++) blk_busy[ino_list[ino][i]] = 0;
            ino_nblk[ino] = 0; ino_busy[ino] = 0; ino_size[ino] = 0;
            r.ino = INO_W'(ino);
        end else begin
            sz = ino_size[ino];
            k = offs / bs;
            r.ino = INO_W'(ino);
            if (offs >= sz || k >= ino_nblk[ino]) begin
                r.status = ST_PAST_END;
            end else begin
                inb = offs % bs;
                stop = (offs + len > sz) ? sz : offs + len;
                v = stop - offs;
                if (v > bs - inb) v = bs - inb;
                r.blk = BLK_W'(ino_list[ino][k]);
                r.in_blk = OFF_W'(inb);
                r.valid_bytes = BS_W'(v);
            end
        end
        r.free_blks = CNT_W'(count_idle_blocks());
        if (op != OP_CREATE) r.size = SIZE_W'(ino_size[ino]);
        return r;
    endfunction

    // result side: ready with random stalls, plus one long hold on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= no_idle || ($urandom_range(99) >= 38);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        alloc_res_t e;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                e = pending_res.pop_front();
                if (o_status != e.status || o_inode_out != e.ino || o_block_out != e.blk ||
                    o_new_blocks != e.new_blks || o_offset_in_block != e.in_blk ||
                    o_bytes_valid != e.valid_bytes || o_free_block_count != e.free_blks ||
                    o_file_size != e.size) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at cycle %0d (result %0d)", cycles, n_results);
                        $display("  exp st=%0d ino=%0d blk=%0d new=%0d off=%0d",
                                 e.status, e.ino, e.blk, e.new_blks, e.in_blk);
                        $display("      val=%0d free=%0d sz=%0d",
                                 e.valid_bytes, e.free_blks, e.size);
                        $display("  got st=%0d ino=%0d blk=%0d new=%0d off=%0d",
                                 o_status, o_inode_out, o_block_out, o_new_blocks,
                                 o_offset_in_block);
                        $display("      val=%0d free=%0d sz=%0d",
                                 o_bytes_valid, o_free_block_count, o_file_size);
                    end
                end
                if (e.status <= ST_PAST_END) status_seen[e.status]++;
            end
        end
    end

    // offer one item (called at a falling edge, returns at a falling edge)
    task automatic put_item(t_op op, logic [INO_W-1:0] ino, logic [LEN_W-1:0] len,
                            logic [LEN_W-1:0] offs, bit typed, alloc_res_t typed_res);
        alloc_res_t r;
        while (!no_idle && $urandom_range(99) < 38) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op; i_inode <= ino; i_length <= len; i_byte_offset <= offs;
        do @(posedge i_clk); while (!o_ready);
        r = run_alloc(op, ino, len, offs);
        pending_res.push_back(typed ? typed_res : r);
        n_items++;
        @(negedge i_clk);
    endtask

    // register write while the block is idle (callers drop i_valid first)
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        wait (pending_res.size() == 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= BS_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BLOCK_SIZE: cfg_bs = value & 'h1FFF;
            CFG_INODES:     cfg_inodes = value & 'h1F;
            CFG_BLOCKS:     cfg_blocks = value & 'h7F;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int bs, int ni, int nb);
        write_reg(CFG_BLOCK_SIZE, bs);
        write_reg(CFG_INODES, ni);
        write_reg(CFG_BLOCKS, nb);
    endtask

    function automatic int pick_len(int bs);
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return $urandom_range(0, 3 * bs);
        if (roll < 85) return $urandom_range(0, 12 * bs);
        return $urandom & 'h3FFFF;
    endfunction

    function automatic int pick_used();
        int list[$];
        for (int i = 0; i < INODES; i++) if (ino_busy[i]) list.push_back(i);
        if (list.size() == 0) return $urandom_range(INODES - 1);
        return list[$urandom_range(list.size() - 1)];
    endfunction

    // mostly well-formed traffic on live files, some noise
    task automatic random_items(int count, int quiet_from, int quiet_to);
        int roll, ino, len, offs, bs;
        alloc_res_t none;
        none = '{ST_OK, '0, '0, '0, '0, '0, '0, '0};
        for (int n = 0; n < count; n++) begin
            no_idle = (n >= quiet_from && n < quiet_to);
            bs = eff_bs();
            roll = $urandom_range(99);
            ino = pick_used();
            if (roll < 22) begin
                put_item(OP_CREATE, INO_W'($urandom), LEN_W'($urandom), LEN_W'($urandom),
                         0, none);
            end else if (roll < 52) begin
                put_item(OP_APPEND, INO_W'(ino), LEN_W'(pick_len(bs)), LEN_W'($urandom),
                         0, none);
            end else if (roll < 82) begin
                len = pick_len(bs);
                if (ino_size[ino] > 0 && $urandom_range(99) < 80)
                    offs = $urandom_range(0, ino_size[ino] - 1);
                else
                    offs = $urandom & 'h3FFFF;
                put_item(OP_MAP, INO_W'(ino), LEN_W'(len), LEN_W'(offs), 0, none);
            end else if (roll < 94) begin
                put_item(OP_DELETE, INO_W'(ino), LEN_W'($urandom), LEN_W'($urandom),
                         0, none);
            end else begin
                put_item(t_op'($urandom_range(3)), INO_W'($urandom), LEN_W'($urandom),
                         LEN_W'($urandom), 0, none);
            end
        end
        no_idle = 0;
        i_valid <= 1'b0;
    endtask

    function automatic void add_row(t_op op, int ino, int len, int offs, int reps,
                                    bit typed, alloc_res_t r);
        dir_row_t d;
        d.op = op; d.ino = INO_W'(ino); d.len = LEN_W'(len); d.offs = LEN_W'(offs);
        d.reps = reps; d.typed = typed; d.res = r;
        dir_tab.push_back(d);
    endfunction

    initial begin
        alloc_res_t x;
        cycles = 0; mismatches = 0; n_items = 0; n_results = 0;
        no_idle = 0; hold_req = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        cfg_bs = 512; cfg_inodes = 16; cfg_blocks = 64;
        foreach (ino_busy[i]) begin
            ino_busy[i] = 0; ino_nblk[i] = 0; ino_size[i] = 0;
        end
        foreach (blk_busy[i]) blk_busy[i] = 0;

        // directed table at reset settings (512-byte blocks, 16 inodes, 64 blocks)
        x = '{ST_OK, '0, '0, '0, '0, '0, '0, '0};
        add_row(OP_MAP, 0, 0, 0, 1, 1, '{ST_BAD_INODE, 0, 0, 0, 0, 0, 64, 0});
        add_row(OP_CREATE, 9, 5, 5, 1, 1, '{ST_OK, 0, 0, 1, 0, 0, 63, 0});
        add_row(OP_APPEND, 0, 0, 0, 1, 1, '{ST_OK, 0, 0, 0, 0, 0, 63, 0});
        add_row(OP_MAP, 0, 0, 0, 1, 1, '{ST_PAST_END, 0, 0, 0, 0, 0, 63, 0});
        add_row(OP_APPEND, 0, 1000, 0, 1, 1, '{ST_OK, 0, 1, 1, 0, 0, 62, 1000});
        add_row(OP_MAP, 0, 1000, 600, 1, 1, '{ST_OK, 0, 1, 0, 88, 400, 62, 1000});
        add_row(OP_MAP, 0, 0, 999, 1, 1, '{ST_OK, 0, 1, 0, 487, 0, 62, 1000});
        add_row(OP_MAP, 0, 5, 1000, 1, 1, '{ST_PAST_END, 0, 0, 0, 0, 0, 62, 1000});
        add_row(OP_APPEND, 0, 'h3FFFF, 0, 1, 1, '{ST_NO_SPACE, 0, 0, 0, 0, 0, 62, 1000});
        add_row(OP_DELETE, 15, 0, 0, 1, 1, '{ST_BAD_INODE, 15, 0, 0, 0, 0, 62, 0});
        add_row(OP_DELETE, 0, 0, 0, 1, 1, '{ST_OK, 0, 0, 0, 0, 0, 64, 0});
        add_row(OP_MAP, 0, 0, 0, 1, 1, '{ST_BAD_INODE, 0, 0, 0, 0, 0, 64, 0});
        // exhaust inodes, then one create too many
        add_row(OP_CREATE, 15, 'h3FFFF, 'h3FFFF, 17, 0, x);
        add_row(OP_MAP, 3, 'h3FFFF, 'h3FFFF, 1, 0, x);
        add_row(OP_APPEND, 5, 'h3FFFF, 0, 1, 0, x);
        add_row(OP_APPEND, 5, 48 * 512 + 512, 0, 1, 0, x);
        add_row(OP_APPEND, 6, 1, 0, 1, 0, x);
        add_row(OP_MAP, 5, 'h3FFFF, 25087, 1, 0, x);
        add_row(OP_MAP, 5, 'h2AAAA, 'h15555, 1, 0, x);
        add_row(OP_DELETE, 5, 0, 0, 1, 0, x);
        add_row(OP_DELETE, 2, 'h3FFFF, 'h3FFFF, 1, 0, x);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[i])
            repeat (dir_tab[i].reps)
                put_item(dir_tab[i].op, dir_tab[i].ino, dir_tab[i].len, dir_tab[i].offs,
                         dir_tab[i].typed, dir_tab[i].res);
        i_valid <= 1'b0;

        // random phases over several settings, extremes and out-of-range values included
        set_config(512, 16, 64);
        hold_req = 1;
        random_items(250, 100, 200);
        set_config(1, 16, 64);
        random_items(150, 0, 0);
        set_config(4096, 1, 1);
        random_items(60, 0, 0);
        set_config(8191, 31, 127);
        random_items(150, 0, 40);
        set_config(0, 0, 0);
        random_items(40, 0, 0);
        set_config(37, 5, 20);
        random_items(200, 50, 90);

        wait (pending_res.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("%0d items sent, %0d results checked over six register settings", n_items,
                 n_results);
        $display("ok %0d, no free %0d, no space %0d, bad inode %0d, past end %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatches == 0 && pending_res.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/fba_pkg.sv
hdl/fba_ram.sv
hdl/fba_div.sv
hdl/fba_dp.sv
hdl/fba_ctrl.sv
hdl/file_block_allocator_top.sv
hdl/fba_chk.sv
sim/tb_file_block_allocator_top.sv
